>>> design/ltpd_pkg.sv
// Shared types, codes and helpers for the line table program decoder.
package ltpd_pkg;

    localparam logic [2:0] PH_MIN     = 3'd0;
    localparam logic [2:0] PH_MAX     = 3'd1;
    localparam logic [2:0] PH_FIRST   = 3'd2;
    localparam logic [2:0] PH_OPCODE  = 3'd3;
    localparam logic [2:0] PH_OPERAND = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    localparam logic [7:0] OP_END           = 8'h00;
    localparam logic [7:0] OP_SET_FILE      = 8'h01;
    localparam logic [7:0] OP_ADVANCE_PC    = 8'h02;
    localparam logic [7:0] OP_ADVANCE_LINE  = 8'h03;
    localparam logic [7:0] OP_FIRST_SPECIAL = 8'h04;

    localparam logic [2:0] KIND_ROW       = 3'd0;
    localparam logic [2:0] KIND_END       = 3'd1;
    localparam logic [2:0] KIND_FOUND     = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [2:0] KIND_BAD       = 3'd4;

    localparam logic [2:0] REG_FIND_MODE = 3'd0;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        start_req;
        logic [63:0] table_base;
        logic [63:0] lookup_address;
    } item_t;

    typedef struct packed {
        logic [63:0] row_address;
        logic [31:0] row_line;
        logic [31:0] row_file;
        logic [2:0]  kind;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [63:0] acc;
        logic [6:0]  shift;
        logic        done;
    } leb_t;

    // One byte of a LEB128 value; bits at or above bit 64 are dropped.
    function automatic leb_t leb_take(input logic [63:0] acc, input logic [6:0] shift,
                                      input logic [7:0] b, input logic is_signed);
        leb_t r;
        r.acc   = acc;
        r.shift = shift;
        if (shift < 7'd64)
        begin
            r.acc   = acc | ({57'd0, b[6:0]} << shift[5:0]);
            r.shift = shift + 7'd7;
        end
        r.done = !b[7];
        if (r.done && is_signed && (r.shift < 7'd64) && b[6])
        begin
            r.acc = r.acc | ({64{1'b1}} << r.shift[5:0]);
        end
        return r;
    endfunction

endpackage

>>> design/ltpd_front.sv
// Input queue that accepts table bytes and hands them to the decoder.
module ltpd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ltpd_pkg::item_t in_item,
    output logic            q_valid,
    input  logic            q_ready,
    output ltpd_pkg::item_t q_item
);

    ltpd_pkg::item_t mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> design/ltpd_back.sv
// Decoder that carries out header fields, opcodes and the special opcode divide.
module ltpd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              find_mode,
    input  logic              q_valid,
    output logic              q_ready,
    input  ltpd_pkg::item_t   q_item,
    input  logic              out_free,
    output logic              res_valid,
    output ltpd_pkg::result_t res
);

    localparam logic [1:0] ST_BYTE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]  st_reg, st_next;
    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  pend_reg, pend_next;
    logic [63:0] acc_reg, acc_next;
    logic [6:0]  sh_reg, sh_next;
    logic [63:0] min_reg, min_next;
    logic [63:0] max_reg, max_next;
    logic [63:0] addr_reg, addr_next;
    logic [31:0] line_reg, line_next;
    logic [31:0] file_reg, file_next;
    logic [63:0] tgt_reg, tgt_next;
    logic [63:0] ha_reg, ha_next;
    logic [31:0] hl_reg, hl_next;
    logic [31:0] hf_reg, hf_next;
    logic        hv_reg, hv_next;
    logic [7:0]  dq_reg, dq_next;
    logic [7:0]  dr_reg, dr_next;
    logic [7:0]  dv_reg, dv_next;
    logic [2:0]  dc_reg, dc_next;

    logic [7:0]  b;
    logic        start;
    logic [2:0]  e_phase;
    logic        is_signed;
    ltpd_pkg::leb_t leb;
    logic [63:0] range;
    logic [7:0]  adj;
    logic        need_div;
    logic [8:0]  trial;
    logic        do_push;
    logic [63:0] pa;
    logic [31:0] pl;
    logic [31:0] pf;

    assign b       = q_item.data_byte;
    assign start   = q_item.start_req;
    assign e_phase = start ? ltpd_pkg::PH_MIN : phase_reg;
    assign is_signed = (e_phase == ltpd_pkg::PH_MIN) || (e_phase == ltpd_pkg::PH_MAX)
                    || ((e_phase == ltpd_pkg::PH_OPERAND)
                        && (pend_reg == ltpd_pkg::OP_ADVANCE_LINE[1:0]));
    assign leb     = ltpd_pkg::leb_take(start ? 64'd0 : acc_reg, start ? 7'd0 : sh_reg,
                                        b, is_signed);
    assign range   = max_reg - min_reg + 64'd1;
    assign adj     = b - ltpd_pkg::OP_FIRST_SPECIAL;
    // A range of zero stands for 2^64; the divide runs only when the quotient is nonzero.
    assign need_div = (range != 64'd0) && ({56'd0, adj} >= range);
    assign trial   = {dr_reg, dq_reg[7]};

    always_comb
    begin
        st_next = st_reg;  phase_next = phase_reg; pend_next = pend_reg;
        acc_next = acc_reg; sh_next = sh_reg; min_next = min_reg; max_next = max_reg;
        addr_next = addr_reg; line_next = line_reg; file_next = file_reg;
        tgt_next = tgt_reg; ha_next = ha_reg; hl_next = hl_reg; hf_next = hf_reg;
        hv_next = hv_reg; dq_next = dq_reg; dr_next = dr_reg; dv_next = dv_reg;
        dc_next = dc_reg;
        q_ready = 1'b0;
        res_valid = 1'b0;
        res = '0;
        do_push = 1'b0;
        pa = addr_reg;
        pl = line_reg;
        pf = file_reg;

        unique case (st_reg)
            ST_BYTE:
            begin
                if (q_valid && out_free)
                begin
                    q_ready = 1'b1;
                    if (start)
                    begin
                        min_next = '0; max_next = '0;
                        addr_next = q_item.table_base; line_next = '0; file_next = 32'd1;
                        tgt_next = q_item.lookup_address;
                        ha_next = '0; hl_next = '0; hf_next = '0; hv_next = 1'b0;
                        phase_next = ltpd_pkg::PH_MIN;
                        pend_next = '0;
                    end
                    unique case (e_phase)
                        ltpd_pkg::PH_MIN:
                        begin
                            acc_next = leb.acc; sh_next = leb.shift;
                            if (leb.done)
                            begin
                                min_next = leb.acc; acc_next = '0; sh_next = '0;
                                phase_next = ltpd_pkg::PH_MAX;
                            end
                        end
                        ltpd_pkg::PH_MAX:
                        begin
                            acc_next = leb.acc; sh_next = leb.shift;
                            if (leb.done)
                            begin
                                max_next = leb.acc; acc_next = '0; sh_next = '0;
                                if ($signed(leb.acc) < $signed(min_reg))
                                begin
                                    phase_next = ltpd_pkg::PH_DONE;
                                    res_valid = 1'b1;
                                    res.kind = ltpd_pkg::KIND_BAD;
                                    res.last = 1'b1;
                                end
                                else
                                begin
                                    phase_next = ltpd_pkg::PH_FIRST;
                                end
                            end
                        end
                        ltpd_pkg::PH_FIRST:
                        begin
                            acc_next = leb.acc; sh_next = leb.shift;
                            if (leb.done)
                            begin
                                line_next = leb.acc[31:0]; acc_next = '0; sh_next = '0;
                                phase_next = ltpd_pkg::PH_OPCODE;
                            end
                        end
                        ltpd_pkg::PH_OPCODE:
                        begin
                            if (b == ltpd_pkg::OP_END)
                            begin
                                phase_next = ltpd_pkg::PH_DONE;
                                res_valid = 1'b1;
                                res.last = 1'b1;
                                if (!find_mode)
                                begin
                                    res.kind = ltpd_pkg::KIND_END;
                                end
                                else if (hv_reg)
                                begin
                                    res.kind = ltpd_pkg::KIND_FOUND;
                                    res.row_address = ha_reg;
                                    res.row_line = hl_reg;
                                    res.row_file = hf_reg;
                                end
                                else
                                begin
                                    res.kind = ltpd_pkg::KIND_NOT_FOUND;
                                end
                            end
                            else if (b <= ltpd_pkg::OP_ADVANCE_LINE)
                            begin
                                pend_next = b[1:0];
                                acc_next = '0; sh_next = '0;
                                phase_next = ltpd_pkg::PH_OPERAND;
                            end
                            else if (need_div)
                            begin
                                dq_next = adj; dr_next = '0; dv_next = range[7:0];
                                dc_next = '0;
                                st_next = ST_DIV;
                            end
                            else
                            begin
                                do_push = 1'b1;
                                pl = line_reg + min_reg[31:0] + {24'd0, adj};
                            end
                        end
                        ltpd_pkg::PH_OPERAND:
                        begin
                            acc_next = leb.acc; sh_next = leb.shift;
                            if (leb.done)
                            begin
                                phase_next = ltpd_pkg::PH_OPCODE;
                                acc_next = '0; sh_next = '0;
                                if (pend_reg == ltpd_pkg::OP_SET_FILE[1:0])
                                begin
                                    file_next = leb.acc[31:0];
                                end
                                else if (pend_reg == ltpd_pkg::OP_ADVANCE_PC[1:0])
                                begin
                                    do_push = 1'b1;
                                    pa = addr_reg + leb.acc;
                                end
                                else
                                begin
                                    line_next = line_reg + leb.acc[31:0];
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                // Restoring divide, one quotient bit per cycle.
                if (trial >= {1'b0, dv_reg})
                begin
                    dr_next = 8'(trial - {1'b0, dv_reg});
                    dq_next = {dq_reg[6:0], 1'b1};
                end
                else
                begin
                    dr_next = trial[7:0];
                    dq_next = {dq_reg[6:0], 1'b0};
                end
                dc_next = dc_reg + 3'd1;
                if (dc_reg == 3'd7)
                begin
                    st_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    do_push = 1'b1;
                    pa = addr_reg + {56'd0, dq_reg};
                    pl = line_reg + min_reg[31:0] + {24'd0, dr_reg};
                    st_next = ST_BYTE;
                end
            end
            default:
            begin
                st_next = ST_BYTE;
            end
        endcase

        if (do_push)
        begin
            addr_next = pa;
            line_next = pl;
            if (!find_mode)
            begin
                res_valid = 1'b1;
                res.row_address = pa; res.row_line = pl; res.row_file = pf;
                res.kind = ltpd_pkg::KIND_ROW;
            end
            else if (tgt_reg < pa)
            begin
                phase_next = ltpd_pkg::PH_DONE;
                res_valid = 1'b1;
                res.last = 1'b1;
                if (hv_reg)
                begin
                    res.kind = ltpd_pkg::KIND_FOUND;
                    res.row_address = ha_reg; res.row_line = hl_reg; res.row_file = hf_reg;
                end
                else
                begin
                    res.kind = ltpd_pkg::KIND_NOT_FOUND;
                end
            end
            else
            begin
                ha_next = pa; hl_next = pl; hf_next = pf; hv_next = 1'b1;
                if (tgt_reg == pa)
                begin
                    phase_next = ltpd_pkg::PH_DONE;
                    res_valid = 1'b1;
                    res.last = 1'b1;
                    res.kind = ltpd_pkg::KIND_FOUND;
                    res.row_address = pa; res.row_line = pl; res.row_file = pf;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_BYTE; phase_reg <= ltpd_pkg::PH_DONE; pend_reg <= '0;
            acc_reg <= '0; sh_reg <= '0; min_reg <= '0; max_reg <= '0;
            addr_reg <= '0; line_reg <= '0; file_reg <= 32'd1; tgt_reg <= '0;
            ha_reg <= '0; hl_reg <= '0; hf_reg <= '0; hv_reg <= 1'b0;
            dc_reg <= '0;
        end
        else
        begin
            st_reg <= st_next; phase_reg <= phase_next; pend_reg <= pend_next;
            acc_reg <= acc_next; sh_reg <= sh_next; min_reg <= min_next;
            max_reg <= max_next; addr_reg <= addr_next; line_reg <= line_next;
            file_reg <= file_next; tgt_reg <= tgt_next; ha_reg <= ha_next;
            hl_reg <= hl_next; hf_reg <= hf_next; hv_reg <= hv_next;
            dc_reg <= dc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg <= dq_next;
        dr_reg <= dr_next;
        dv_reg <= dv_next;
    end

endmodule

>>> design/line_table_program_decoder_core.sv
// Line table program decoder: byte stream in, decoded rows or lookup result out.
//
// Input channel (in_valid/in_ready) moves one table byte per transaction with
// start_req marking the first byte of a table; table_base and lookup_address
// are sampled on that byte. Output channel (out_valid/out_ready) moves one result
// per transaction: a row, an end marker, a lookup result or a bad header flag.
// find_mode is written over the APB port at address 0; the user must write it
// only while idle, which the block does not enforce. A two-entry input queue
// decouples the byte source from the decoder. A special opcode with a nonzero
// address delta goes through the bit-serial 8-bit divide by the line range. A
// result is registered and shows on the output in the cycle after its byte is
// decoded. While the receiver stalls, the held result stays and the decoder
// waits for the output register to free; the queue keeps taking bytes until full.
// After reset no table is open and bytes without start_req give no result.
module line_table_program_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_req,
    input  logic [63:0] table_base,
    input  logic [63:0] lookup_address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] row_address,
    output logic [31:0] row_line,
    output logic [31:0] row_file,
    output logic [2:0]  kind,
    output logic        last
);

    logic              find_mode_reg;
    logic              q_valid;
    logic              q_ready;
    ltpd_pkg::item_t   in_item;
    ltpd_pkg::item_t   q_item;
    logic              out_free;
    logic              res_valid;
    ltpd_pkg::result_t res;
    ltpd_pkg::result_t out_reg;
    logic              ov_reg, ov_next;

    assign pready = 1'b1;
    assign prdata = (paddr == ltpd_pkg::REG_FIND_MODE) ? {31'd0, find_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            find_mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr == ltpd_pkg::REG_FIND_MODE))
        begin
            find_mode_reg <= pwdata[0];
        end
    end

    assign in_item.data_byte      = data_byte;
    assign in_item.start_req      = start_req;
    assign in_item.table_base     = table_base;
    assign in_item.lookup_address = lookup_address;

    ltpd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    assign out_free = !ov_reg || out_ready;

    ltpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .find_mode (find_mode_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    assign ov_next = res_valid ? 1'b1 : (out_ready ? 1'b0 : ov_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = ov_reg;
    assign row_address = out_reg.row_address;
    assign row_line    = out_reg.row_line;
    assign row_file    = out_reg.row_file;
    assign kind        = out_reg.kind;
    assign last        = out_reg.last;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!ov_reg || out_ready))
        else $error("result produced while output register is occupied");

    a_row_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == ltpd_pkg::KIND_ROW)) |-> !last)
        else $error("row result marked as last");

    a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind != ltpd_pkg::KIND_ROW)) |-> last)
        else $error("final result not marked as last");
`endif

endmodule
